// ===== rtl/rational_arithmetic_unit_core_assert.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
// Requires a clock and an active-low reset named clk_i and rst_ni in scope.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define RAU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, status codes,
// and the record passed from the front end to the back end. No dependencies.
`default_nettype none
package rau_pkg;

  localparam int unsigned OperandBits = 32;
  localparam int unsigned PortBits    = 32;
  localparam int unsigned DenBits     = 31;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Classified item: either an early result or operands to be processed.
  typedef struct packed {
    logic            early;
    logic [1:0]      early_status;
    logic [2:0]      op;
    logic            an_neg;
    logic [32:0]     an_mag;
    logic            ad_neg;
    logic [32:0]     ad_mag;
    logic            bn_neg;
    logic [32:0]     bn_mag;
    logic            bd_neg;
    logic [32:0]     bd_mag;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/rau_front.sv =====
// Front end of the rational arithmetic unit: converts operands to sign and
// magnitude and flags zero denominators and bad op codes. Depends on rau_pkg.
`default_nettype none
module rau_front #(
  parameter int unsigned OperandBits = rau_pkg::OperandBits
) (
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output rau_pkg::item_t   item_o
);

  function automatic logic [33:0] to_smag(input logic [31:0] v);
    logic [OperandBits-1:0] m;
    logic                   n;
    logic [32:0]            mag;
    begin
      m   = v[OperandBits-1:0];
      n   = m[OperandBits-1];
      mag = 33'(m);
      if (n) begin
        mag = (33'd1 << OperandBits) - mag;
      end
      to_smag = {n, mag};
    end
  endfunction

  logic [33:0] an, ad, bn, bd;
  logic        bad;

  always_comb begin
    an = to_smag(a_num_i);
    ad = to_smag(a_den_i);
    bn = to_smag(b_num_i);
    bd = to_smag(b_den_i);
    bad = (op_i > 3'(rau_pkg::OP_NEG)) || (ad[32:0] == '0)
        || ((op_i != 3'(rau_pkg::OP_NEG)) && (bd[32:0] == '0))
        || ((op_i == 3'(rau_pkg::OP_DIV)) && (bn[32:0] == '0));
    item_o.early        = bad;
    item_o.early_status = 2'(rau_pkg::ST_ZERO_DEN);
    item_o.op           = op_i;
    item_o.an_neg       = an[33];
    item_o.an_mag       = an[32:0];
    item_o.ad_neg       = ad[33];
    item_o.ad_mag       = ad[32:0];
    item_o.bn_neg       = bn[33];
    item_o.bn_mag       = bn[32:0];
    item_o.bd_neg       = bd[33];
    item_o.bd_mag       = bd[32:0];
  end

endmodule
`default_nettype wire

// ===== rtl/rau_queue.sv =====
// Two-entry queue between the front and back ends of the rational unit.
// Depends on rau_pkg for the item record.
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
module rau_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rau_pkg::item_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output rau_pkg::item_t       data_o,
  output logic                 empty_o
);

  rau_pkg::item_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `RAU_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count out of range")
  `RAU_ASSERT(a_ptr_match, (cnt_q != 2'd1) || (wp_q != rp_q), "pointers disagree with count")
  `RAU_ASSERT(a_push_grows, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "push lost")

endmodule
`default_nettype wire

// ===== rtl/rau_back.sv =====
// Back end of the rational arithmetic unit: forms the raw fraction with a
// shared 33x33 multiplier, reduces it by an iterative gcd and two serial
// divisions, and holds the result in an output register. Depends on rau_pkg.
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
module rau_back #(
  parameter int unsigned OperandBits = rau_pkg::OperandBits
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rau_pkg::item_t item_i,
  input  wire logic           item_valid_i,
  output logic                item_take_o,
  output logic [31:0]         res_num_o,
  output logic [30:0]         res_den_o,
  output logic [1:0]          status_o,
  output logic                empty_o,
  input  wire logic           pop_i
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_MUL3 = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DIVN = 8'b0010_0000,
    S_DIVD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  rau_pkg::item_t it_q;
  logic [65:0] p_q;            // product register
  logic        p_neg_q;
  logic        t1_neg_q;
  logic [65:0] t1_q;
  logic        num_neg_q, den_neg_q;
  logic [65:0] num_q, den_q;
  logic [65:0] gx_q, gy_q;     // binary gcd operands
  logic [6:0]  gsh_q;          // common power of two
  logic [65:0] g_q;
  logic [65:0] quo_q, rem_q, dvd_q;
  logic [6:0]  bit_q;
  logic        out_v_q;
  logic [31:0] out_num_q;
  logic [30:0] out_den_q;
  logic [1:0]  out_st_q;

  // Shared multiplier operands.
  logic        ma_neg, mb_neg;
  logic [32:0] ma_mag, mb_mag;
  logic [65:0] m_prod;

  always_comb begin
    ma_neg = it_q.an_neg; ma_mag = it_q.an_mag;
    mb_neg = it_q.bd_neg; mb_mag = it_q.bd_mag;
    case (state_q)
      S_MUL1: begin
        if (it_q.op == 3'(rau_pkg::OP_MUL)) begin
          mb_neg = it_q.bn_neg; mb_mag = it_q.bn_mag;
        end
      end
      S_MUL2: begin
        if (it_q.op == 3'(rau_pkg::OP_ADD) || it_q.op == 3'(rau_pkg::OP_SUB)) begin
          ma_neg = it_q.bn_neg; ma_mag = it_q.bn_mag;
          mb_neg = it_q.ad_neg; mb_mag = it_q.ad_mag;
        end else if (it_q.op == 3'(rau_pkg::OP_DIV)) begin
          ma_neg = it_q.ad_neg; ma_mag = it_q.ad_mag;
          mb_neg = it_q.bn_neg; mb_mag = it_q.bn_mag;
        end else begin
          ma_neg = it_q.ad_neg; ma_mag = it_q.ad_mag;
        end
      end
      S_MUL3: begin
        ma_neg = it_q.ad_neg; ma_mag = it_q.ad_mag;
      end
      default: ;
    endcase
    m_prod = 66'(ma_mag) * 66'(mb_mag);
  end

  // Sign-magnitude add of the first term and the registered second product, whose sign is inverted for OP_SUB.
  logic        s_neg;
  logic [65:0] s_mag;
  logic        p2_neg;
  always_comb begin
    p2_neg = p_neg_q ^ (it_q.op == 3'(rau_pkg::OP_SUB));
    if (t1_neg_q == p2_neg) begin
      s_neg = t1_neg_q; s_mag = t1_q + p_q;
    end else if (t1_q >= p_q) begin
      s_neg = t1_neg_q; s_mag = t1_q - p_q;
    end else begin
      s_neg = p2_neg;   s_mag = p_q - t1_q;
    end
  end

  // Restoring division step of dvd_q by g_q.
  logic [66:0] r_sh;
  logic [65:0] r_next;
  logic        q_bit;
  always_comb begin
    r_sh   = {rem_q, dvd_q[bit_q]};
    q_bit  = r_sh >= 67'(g_q);
    r_next = q_bit ? 66'(r_sh - 67'(g_q)) : r_sh[65:0];
  end

  logic [65:0] lim;
  logic        neg_r;
  logic        ovf;
  assign lim   = 66'd1 << (OperandBits - 1);
  assign neg_r = num_neg_q ^ den_neg_q;
  assign ovf   = (quo_q > lim - 66'd1);
  logic        num_ovf;
  assign num_ovf = neg_r ? (num_q > lim) : (num_q > lim - 66'd1);

  logic [65:0] gd, gx_n, gy_n;
  always_comb begin
    gd   = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
    gx_n = (gx_q < gy_q) ? gx_q : gy_q;
    gy_n = gd;
  end

  assign item_take_o = (state_q == S_IDLE) && item_valid_i && (!out_v_q || pop_i);
  assign empty_o     = !out_v_q;
  assign res_num_o   = out_num_q;
  assign res_den_o   = out_den_q;
  assign status_o    = out_st_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (item_take_o && !item_i.early) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = (it_q.op == 3'(rau_pkg::OP_ADD) || it_q.op == 3'(rau_pkg::OP_SUB))
                        ? S_MUL3 : S_GCD;
      S_MUL3: state_d = S_GCD;
      S_GCD:  if (num_q == '0) state_d = S_DONE;
              else if (gy_q == '0) state_d = S_DIVN;
      S_DIVN: if (bit_q == 7'd0) state_d = S_DIVD;
      S_DIVD: if (bit_q == 7'd0) state_d = S_DONE;
      S_DONE: if (!out_v_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && out_v_q) out_v_q <= 1'b0;
      if (item_take_o && item_i.early) out_v_q <= 1'b1;
      if (state_q == S_DONE && !out_v_q) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      it_q <= item_i;
      if (item_i.early) begin
        out_num_q <= '0;
        out_den_q <= '0;
        out_st_q  <= item_i.early_status;
      end
    end
    case (state_q)
      S_MUL1: begin
        p_q <= m_prod; p_neg_q <= ma_neg ^ mb_neg;
        if (it_q.op == 3'(rau_pkg::OP_NEG)) begin
          num_q <= 66'(it_q.an_mag); num_neg_q <= !it_q.an_neg;
        end
      end
      S_MUL2: begin
        if (it_q.op == 3'(rau_pkg::OP_ADD) || it_q.op == 3'(rau_pkg::OP_SUB)) begin
          t1_q <= p_q; t1_neg_q <= p_neg_q;
          p_q <= m_prod; p_neg_q <= ma_neg ^ mb_neg;
        end else begin
          if (it_q.op == 3'(rau_pkg::OP_NEG)) begin
            den_q <= 66'(it_q.ad_mag); den_neg_q <= it_q.ad_neg;
            gx_q <= num_q; gy_q <= 66'(it_q.ad_mag);
          end else begin
            num_q <= p_q; num_neg_q <= p_neg_q;
            den_q <= m_prod; den_neg_q <= ma_neg ^ mb_neg;
            gx_q <= p_q; gy_q <= m_prod;
          end
          gsh_q <= '0;
        end
      end
      S_MUL3: begin
        num_q <= s_mag; num_neg_q <= s_neg;
        den_q <= m_prod; den_neg_q <= ma_neg ^ mb_neg;
        gx_q <= s_mag; gy_q <= m_prod;
        gsh_q <= '0;
      end
      S_GCD: begin
        // Binary gcd: strip common twos, then subtract-and-halve.
        if (gy_q == '0) begin
          g_q   <= gx_q << gsh_q;
          rem_q <= '0; quo_q <= '0; dvd_q <= num_q;
          bit_q <= 7'd65;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gsh_q <= gsh_q + 7'd1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else begin
          gx_q <= gx_n; gy_q <= gy_n >> 1;
        end
        if (num_q == '0) begin
          out_num_q <= '0; out_den_q <= 31'd1; out_st_q <= 2'(rau_pkg::ST_OK);
        end
      end
      S_DIVN, S_DIVD: begin
        rem_q <= r_next;
        quo_q <= {quo_q[64:0], q_bit};
        if (bit_q == 7'd0) begin
          if (state_q == S_DIVN) begin
            num_q <= {quo_q[64:0], q_bit};
            rem_q <= '0; quo_q <= '0; dvd_q <= den_q; bit_q <= 7'd65;
          end else begin
            quo_q <= {quo_q[64:0], q_bit};
          end
        end else begin
          bit_q <= bit_q - 7'd1;
        end
      end
      S_DONE: begin
        if (!out_v_q && num_q != '0) begin
          if (ovf || num_ovf) begin
            out_num_q <= '0; out_den_q <= '0; out_st_q <= 2'(rau_pkg::ST_OVERFLOW);
          end else begin
            out_num_q <= neg_r ? 32'(66'd0 - num_q) : num_q[31:0];
            out_den_q <= quo_q[30:0];
            out_st_q  <= 2'(rau_pkg::ST_OK);
          end
        end
      end
      default: ;
    endcase
  end

  `RAU_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
  `RAU_ASSERT(a_take_idle, item_take_o |-> (state_q == S_IDLE), "item taken while busy")
  `RAU_ASSERT(a_hold, (out_v_q && !pop_i) |=> ($stable(res_num_o) && $stable(status_o)), "result changed while waiting")

endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: one result per item, gcd-reduced fraction.
// Time per item is set by the binary gcd loop and two 66-step restoring
// divisions; error items finish without entering the gcd loop, and items with
// a zero result skip the divisions.
// Throughput: one item at a time in the back end; two items queue in front.
// Reset: asynchronous, active low; clears queue and back end, no results held.
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int unsigned OperandBits = rau_pkg::OperandBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      res_num_o,
  output logic [30:0]      res_den_o,
  output logic [1:0]       status_o
);

  rau_pkg::item_t f_item, q_item;
  logic           q_empty, q_take;

  rau_front #(.OperandBits(OperandBits)) u_front (
    .op_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i, .item_o(f_item)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_item), .full_o(full),
    .pop_i(q_take), .data_o(q_item), .empty_o(q_empty)
  );

  rau_back #(.OperandBits(OperandBits)) u_back (
    .clk_i, .rst_ni, .item_i(q_item), .item_valid_i(!q_empty), .item_take_o(q_take),
    .res_num_o, .res_den_o, .status_o, .empty_o(empty), .pop_i(pop)
  );

endmodule
`default_nettype wire
